// ===== hdl/lpd_pkg.sv =====
`timescale 1ns / 1ps
// lpd_pkg: shared types and constants of the length-prefix deframer
// no dependencies

package lpd_pkg;

  localparam int unsigned MAX_LEN_WIDTH = 16;
  localparam logic [MAX_LEN_WIDTH-1:0] MAX_LEN_RESET = 16'hFFFF;

  localparam logic [7:0] SEPARATOR_BYTE = 8'h40;  // '@'
  localparam logic [7:0] ASCII_ZERO     = 8'h30;
  localparam logic [7:0] ASCII_NINE     = 8'h39;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_TOO_LONG = 2'd2
  } error_code_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        string_end;
    error_code_t error_code;
  } result_t;

endpackage

// ===== hdl/lpd_parser.sv =====
`timescale 1ns / 1ps
// lpd_parser: length/payload parse state and the per-byte step
// depends on lpd_pkg

module lpd_parser #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [7:0]                     in_byte,
  input  logic [lpd_pkg::MAX_LEN_WIDTH-1:0] max_len,
  output logic                           res_valid,
  output lpd_pkg::result_t               res
);
  import lpd_pkg::*;

  localparam int unsigned PROD_WIDTH = LENGTH_WIDTH + 4;
  localparam int unsigned CMP_WIDTH  =
    (PROD_WIDTH > MAX_LEN_WIDTH) ? PROD_WIDTH : MAX_LEN_WIDTH;

  logic                    in_payload;
  logic                    in_payload_next;
  logic [LENGTH_WIDTH-1:0] length_count;
  logic [LENGTH_WIDTH-1:0] length_count_next;

  logic [PROD_WIDTH-1:0]   count_ext;
  logic [PROD_WIDTH-1:0]   prod;
  logic                    is_digit;
  logic                    too_long;

  assign is_digit  = (in_byte >= ASCII_ZERO) && (in_byte <= ASCII_NINE);
  assign count_ext = {4'b0000, length_count};
  // count * 10 + digit, as two shifts and two adds
  assign prod      = (count_ext << 3) + (count_ext << 1)
                   + {{(PROD_WIDTH-4){1'b0}}, in_byte[3:0]};
  assign too_long  = (prod[PROD_WIDTH-1:LENGTH_WIDTH] != 4'b0000)
                   || (CMP_WIDTH'(prod) > CMP_WIDTH'(max_len));

  always_comb begin
    in_payload_next   = in_payload;
    length_count_next = length_count;
    res_valid         = 1'b0;
    res.out_byte      = 8'h00;
    res.has_byte      = 1'b0;
    res.string_end    = 1'b0;
    res.error_code    = ERR_NONE;
    if (in_payload) begin
      res_valid    = 1'b1;
      res.out_byte = in_byte;
      res.has_byte = 1'b1;
      if (length_count <= LENGTH_WIDTH'(1)) begin
        res.string_end    = 1'b1;
        in_payload_next   = 1'b0;
        length_count_next = '0;
      end else begin
        length_count_next = length_count - LENGTH_WIDTH'(1);
      end
    end else if (is_digit) begin
      if (too_long) begin
        res_valid         = 1'b1;
        res.error_code    = ERR_TOO_LONG;
        length_count_next = '0;
      end else begin
        length_count_next = prod[LENGTH_WIDTH-1:0];
      end
    end else if (in_byte == SEPARATOR_BYTE) begin
      if (length_count == '0) begin
        // empty string: one end marker, stay in length mode
        res_valid      = 1'b1;
        res.string_end = 1'b1;
      end else begin
        in_payload_next = 1'b1;
      end
    end else begin
      res_valid         = 1'b1;
      res.error_code    = ERR_BAD_CHAR;
      length_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload   <= 1'b0;
      length_count <= '0;
    end else if (accept) begin
      in_payload   <= in_payload_next;
      length_count <= length_count_next;
    end
  end

endmodule

// ===== hdl/lpd_out_buf.sv =====
`timescale 1ns / 1ps
// lpd_out_buf: two-entry result register with skid slot
// depends on lpd_pkg

module lpd_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lpd_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output lpd_pkg::result_t out_data
);
  import lpd_pkg::*;

  logic [1:0] fill;
  logic [1:0] fill_next;
  result_t    head;
  result_t    tail;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (fill != 2'd0);
  assign full      = (fill == 2'd2);
  assign out_data  = head;

  always_comb begin
    fill_next = fill;
    case ({push, pop})
      2'b10:   fill_next = fill + 2'd1;
      2'b01:   fill_next = fill - 2'd1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill_next;
    end
  end

  // payload slots, no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && fill == 2'd1) begin
        head <= push_data;
      end else begin
        head <= tail;
      end
      if (push && fill == 2'd2) begin
        tail <= push_data;
      end
    end else if (push) begin
      if (fill == 2'd0) begin
        head <= push_data;
      end else begin
        tail <= push_data;
      end
    end
  end

endmodule

// ===== hdl/length_prefix_deframer.sv =====
`timescale 1ns / 1ps
// length_prefix_deframer: top level, config register and glue
// depends on lpd_pkg, lpd_parser, lpd_out_buf

// Splits a byte stream of records "<decimal length>@<payload>" into strings.
// One input word is taken per clock cycle while in_stall is low; each word
// gives at most one result word, which appears at the earliest in the cycle
// after acceptance. Length digits give no result; '@' with a zero length
// gives one empty-string end marker; bad characters and lengths over
// max_string_length give an error word and restart the parser. The result
// side has a two-word buffer, so in_stall rises only when two results are
// waiting. The user must write max_string_length through the cfg port
// (always ready) only while the block is idle; the block does not enforce it.

module length_prefix_deframer #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        has_byte,
  output logic        string_end,
  output logic [1:0]  error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import lpd_pkg::*;

  logic [MAX_LEN_WIDTH-1:0] max_string_length;
  logic                     accept;
  logic                     res_valid;
  result_t                  res;
  logic                     buf_full;
  result_t                  out_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign accept    = in_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_string_length <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_string_length <= cfg_data;
    end
  end

  lpd_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .max_len   (max_string_length),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_byte   = out_data.out_byte;
  assign has_byte   = out_data.has_byte;
  assign string_end = out_data.string_end;
  assign error_code = out_data.error_code;

endmodule

// ===== tb/tb_length_prefix_deframer.sv =====
`timescale 1ns / 1ps
// tb_length_prefix_deframer: self-checking bench for the length-prefix deframer
// feeds directed and random byte streams, predicts each result word and compares
// depends on lpd_pkg and length_prefix_deframer

module tb_length_prefix_deframer;
  import lpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES   = 135;
  localparam logic [7:0]  RESYNC_BYTE   = 8'h2F;  // '/', a bad char in length mode

  typedef struct {
    logic [7:0] data;
    bit         drain;  // hold this word back until every result is in
  } stream_byte_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        has_byte;
  logic        string_end;
  logic [1:0]  error_code;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  stream_byte_t stream_q[$];
  result_t      expected_words[$];

  // deframer state as the block should hold it
  bit           in_string = 1'b0;
  logic [15:0]  len_left = '0;
  logic [15:0]  max_len_cfg = MAX_LEN_RESET;

  int unsigned  sender_idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;

  length_prefix_deframer u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .string_end (string_end),
    .error_code (error_code),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void expect_word(input logic [7:0] b, input logic has,
                                      input logic last, input error_code_t err);
    result_t w;
    w.out_byte   = b;
    w.has_byte   = has;
    w.string_end = last;
    w.error_code = err;
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [31:0] next_len;
    if (in_string) begin
      if (len_left <= 16'd1) begin
        in_string = 1'b0;
        len_left = '0;
        expect_word(b, 1'b1, 1'b1, ERR_NONE);
      end else begin
        len_left = len_left - 16'd1;
        expect_word(b, 1'b1, 1'b0, ERR_NONE);
      end
    end else if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
      next_len = 32'(len_left) * 32'd10 + 32'(b - ASCII_ZERO);
      if (next_len > 32'(max_len_cfg) || next_len > 32'h0000_FFFF) begin
        len_left = '0;
        expect_word(8'h00, 1'b0, 1'b0, ERR_TOO_LONG);
      end else begin
        len_left = next_len[15:0];
      end
    end else if (b == SEPARATOR_BYTE) begin
      // an empty string ends right at the separator
      if (len_left == '0)
        expect_word(8'h00, 1'b0, 1'b1, ERR_NONE);
      else
        in_string = 1'b1;
    end else begin
      len_left = '0;
      expect_word(8'h00, 1'b0, 1'b0, ERR_BAD_CHAR);
    end
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    stream_byte_t e;
    e.data  = b;
    e.drain = 1'b0;
    stream_q.insert(stream_q.size(), e);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i]);
  endfunction

  function automatic void push_number(input int unsigned v, input int unsigned zeros);
    logic [7:0] digits[$];
    repeat (zeros) push_byte(ASCII_ZERO);
    do begin
      digits.push_front(8'(ASCII_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i])
      push_byte(digits[i]);
  endfunction

  // one record, mostly well formed, some broken on purpose
  function automatic void queue_record();
    int unsigned pick;
    int unsigned len;
    int unsigned lim;
    int unsigned zeros;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    lim = 32'(max_len_cfg);
    zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    if (pick < 70) begin
      len = $urandom_range(0, 12);
      if ($urandom_range(0, 9) == 0)
        len = (lim <= 300) ? lim : $urandom_range(13, 300);
      if (len > lim)
        len = lim;
      push_number(len, zeros);
      push_byte(SEPARATOR_BYTE);
      repeat (len) begin
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0)
          b = $urandom_range(0, 1) ? SEPARATOR_BYTE : 8'(ASCII_ZERO + $urandom_range(0, 9));
        push_byte(b);
      end
    end else if (pick < 80) begin
      // every prefix fits, the final digit pushes the count over the limit
      if (lim == 0)
        push_number($urandom_range(1, 9), zeros);
      else
        push_number($urandom_range(lim / 10 + 1, lim) * 10 + $urandom_range(0, 9), zeros);
    end else if (pick < 90) begin
      if ($urandom_range(0, 1))
        push_number($urandom_range(0, lim), zeros);
      do
        b = 8'($urandom_range(0, 255));
      while ((b >= ASCII_ZERO && b <= ASCII_NINE) || b == SEPARATOR_BYTE);
      push_byte(b);
    end else if (pick < 95) begin
      if ($urandom_range(0, 1))
        push_number(0, $urandom_range(0, 2));
      push_byte(SEPARATOR_BYTE);
    end else begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      push_byte(RESYNC_BYTE);
    end
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic write_max_len(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    max_len_cfg = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (stream_q.size() != 0 || expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: holds a stalled word, otherwise offers the next one or idles
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_byte);
        void'(stream_q.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (stream_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct &&
            !(stream_q[0].drain && expected_words.size() != 0)) begin
          in_valid <= 1'b1;
          in_byte <= stream_q[0].data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each accepted word against the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word byte=%02h has=%0b end=%0b err=%0d",
                                    out_byte, has_byte, string_end, error_code));
        end else begin
          want = expected_words.pop_front();
          if (out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.out_byte));
          if (has_byte !== want.has_byte)
            report_mismatch($sformatf("has_byte %0b, want %0b", has_byte, want.has_byte));
          if (string_end !== want.string_end)
            report_mismatch($sformatf("string_end %0b, want %0b", string_end,
                                      want.string_end));
          if (error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, want %0d", error_code,
                                      want.error_code));
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("length_prefix_deframer regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned mode;
    logic [15:0] limits[12];
    limits = '{16'd65535, 16'd0, 16'd1, 16'd9, 16'd10, 16'd100, 16'd255, 16'd0,
               16'd12345, 16'd3, 16'd65535, 16'd0};
    limits[7] = 16'($urandom_range(0, 65535));
    limits[11] = 16'($urandom_range(0, 65535));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_max_len(MAX_LEN_RESET);

    // zero length, bare separator, leading zero with odd payload, bad chars, overflow, one-byte string
    push_text("0@");
    push_text("@");
    push_text("03@");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(SEPARATOR_BYTE);
    push_byte(8'h2F);
    push_byte(8'h3A);
    push_byte(8'h3F);
    push_byte(8'h41);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("65536");
    push_text("1@5");
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      mode = p / 4;
      sender_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 84 : 0;
      stall_pct = (mode == 0) ? 84 : (mode == 1) ? 31 : 0;
      write_max_len(limits[p]);
      while (stream_q.size() < PHASE_BYTES)
        queue_record();
      stream_q[stream_q.size() / 2].drain = 1'b1;
      wait_idle();
    end

    if (fail_count == 0)
      $display("length_prefix_deframer regression: pass");
    else
      $display("length_prefix_deframer regression: fail");
    $finish;
  end

endmodule

// ===== length_prefix_deframer.f =====
hdl/lpd_pkg.sv
hdl/lpd_parser.sv
hdl/lpd_out_buf.sv
hdl/length_prefix_deframer.sv
tb/tb_length_prefix_deframer.sv
